// ----- rtl/core/kpl_pkg.sv -----
// ----------------------------------------------------------------------------
// Keypad passcode lock package
// Shared codes, register indexes, reset values and the item types that pass
// between the front end, the back end and the result queue.
// ----------------------------------------------------------------------------
package kpl_pkg;

  // Width of the typed and stored passcodes.
  localparam int KPL_CODE_WIDTH = 16;

  // Input opcodes.
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_CHANGE = 2'd1;
  localparam logic [1:0] OP_LINK   = 2'd2;

  // Keypad keys (ASCII).
  localparam logic [7:0] KEY_0     = 8'h30;
  localparam logic [7:0] KEY_9     = 8'h39;
  localparam logic [7:0] KEY_CLEAR = 8'h3F;
  localparam logic [7:0] KEY_ENTER = 8'h3D;

  // Lock modes.
  localparam logic [2:0] MODE_CREATE = 3'd0;
  localparam logic [2:0] MODE_CHANGE = 3'd1;
  localparam logic [2:0] MODE_ENTER  = 3'd2;
  localparam logic [2:0] MODE_OPEN   = 3'd3;
  localparam logic [2:0] MODE_BANNED = 3'd4;

  // Miss counter saturates here.
  localparam logic [2:0] MISS_MAX = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TRIAL_LIMIT = 2'd0;
  localparam logic [1:0] CFG_CLOSED      = 2'd1;
  localparam logic [1:0] CFG_STOP_ALARM  = 2'd2;

  // Configuration reset values.
  localparam logic [2:0] RST_TRIAL_LIMIT = 3'd3;
  localparam logic [7:0] RST_CLOSED      = 8'd3;
  localparam logic [7:0] RST_STOP_ALARM  = 8'd4;

  // Classified event kinds.
  localparam logic [2:0] EV_NOP    = 3'd0;
  localparam logic [2:0] EV_DIGIT  = 3'd1;
  localparam logic [2:0] EV_CLEAR  = 3'd2;
  localparam logic [2:0] EV_ENTER  = 3'd3;
  localparam logic [2:0] EV_CHGREQ = 3'd4;
  localparam logic [2:0] EV_LINK   = 3'd5;

  // One classified event, as queued between front and back.
  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] digit;
    logic       hit_closed;
    logic       hit_stop;
  } ev_t;

  // One result item.
  typedef struct packed {
    logic       send_valid;
    logic       verdict;
    logic [2:0] lock_mode;
    logic [2:0] misses;
  } res_t;

endpackage

// ----- rtl/core/kpl_fifo.sv -----
// ----------------------------------------------------------------------------
// Keypad passcode lock two-entry queue
// Small register queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module kpl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int DEPTH = 2;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// ----- rtl/core/kpl_front.sv -----
// ----------------------------------------------------------------------------
// Keypad passcode lock front end
// Accepts input items, classifies them into events and queues the events.
// ----------------------------------------------------------------------------
module kpl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_key_code,
  input  logic [7:0]        in_link_byte,
  input  logic [7:0]        closed_byte,
  input  logic [7:0]        stop_alarm_byte,
  output logic              ev_valid,
  output kpl_pkg::ev_t      ev,
  input  logic              ev_pop
);

  import kpl_pkg::*;

  ev_t        ev_in;
  logic [7:0] key_off;
  logic       ev_empty;

  assign key_off = in_key_code - KEY_0;

  always_comb begin
    ev_in            = '0;
    ev_in.kind       = EV_NOP;
    ev_in.digit      = key_off[3:0];
    ev_in.hit_closed = (in_link_byte == closed_byte);
    ev_in.hit_stop   = (in_link_byte == stop_alarm_byte);
    unique case (in_opcode)
      OP_KEY: begin
        if (in_key_code >= KEY_0 && in_key_code <= KEY_9) begin
          ev_in.kind = EV_DIGIT;
        end else if (in_key_code == KEY_CLEAR) begin
          ev_in.kind = EV_CLEAR;
        end else if (in_key_code == KEY_ENTER) begin
          ev_in.kind = EV_ENTER;
        end
      end
      OP_CHANGE: ev_in.kind = EV_CHGREQ;
      OP_LINK:   ev_in.kind = EV_LINK;
      default:   ev_in.kind = EV_NOP;
    endcase
  end

  kpl_fifo #(
    .WIDTH ($bits(ev_t))
  ) u_evq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (ev_in),
    .full  (in_full),
    .pop   (ev_pop),
    .rdata (ev),
    .empty (ev_empty)
  );

  assign ev_valid = !ev_empty;

endmodule

// ----- rtl/core/kpl_back.sv -----
// ----------------------------------------------------------------------------
// Keypad passcode lock back end
// Carries out one classified event per cycle on the lock state while res_ready is high.
// ----------------------------------------------------------------------------
module kpl_back #(
  parameter int CODE_WIDTH = kpl_pkg::KPL_CODE_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ev_valid,
  input  kpl_pkg::ev_t  ev,
  output logic          ev_pop,
  input  logic [2:0]    trial_limit,
  output logic          res_valid,
  output kpl_pkg::res_t res,
  input  logic          res_ready
);

  import kpl_pkg::*;

  logic [2:0]            mode_r;
  logic [2:0]            mode_nxt;
  logic [CODE_WIDTH-1:0] stored_r;
  logic [CODE_WIDTH-1:0] stored_nxt;
  logic [CODE_WIDTH-1:0] typed_r;
  logic [CODE_WIDTH-1:0] typed_nxt;
  logic [CODE_WIDTH-1:0] typed_digit;
  logic [2:0]            miss_r;
  logic [2:0]            miss_nxt;
  logic [2:0]            miss_inc;
  logic                  pend_r;
  logic                  pend_nxt;
  logic                  send;
  logic                  verdict;
  logic                  step;
  logic                  editing;

  assign step      = ev_valid && res_ready;
  assign ev_pop    = step;
  assign res_valid = step;

  // typed * 10 + digit, wrapping at the code width.
  assign typed_digit = (typed_r << 3) + (typed_r << 1)
                     + {{(CODE_WIDTH-4){1'b0}}, ev.digit};
  assign miss_inc    = (miss_r == MISS_MAX) ? miss_r : miss_r + 3'd1;
  assign editing     = (mode_r == MODE_CREATE) || (mode_r == MODE_CHANGE)
                    || (mode_r == MODE_ENTER);

  always_comb begin
    mode_nxt   = mode_r;
    stored_nxt = stored_r;
    typed_nxt  = typed_r;
    miss_nxt   = miss_r;
    pend_nxt   = pend_r;
    send       = 1'b0;
    verdict    = 1'b0;
    unique case (ev.kind)
      EV_DIGIT: if (editing) typed_nxt = typed_digit;
      EV_CLEAR: if (editing) typed_nxt = '0;
      EV_ENTER: begin
        if (mode_r == MODE_CREATE || mode_r == MODE_CHANGE) begin
          stored_nxt = typed_r;
          typed_nxt  = '0;
          miss_nxt   = '0;
          pend_nxt   = 1'b0;
          mode_nxt   = MODE_ENTER;
        end else if (mode_r == MODE_ENTER) begin
          send      = 1'b1;
          typed_nxt = '0;
          if (typed_r == stored_r) begin
            verdict  = 1'b1;
            miss_nxt = '0;
            mode_nxt = MODE_OPEN;
          end else begin
            miss_nxt = miss_inc;
            if (miss_inc >= trial_limit) mode_nxt = MODE_BANNED;
          end
        end
      end
      EV_CHGREQ: pend_nxt = 1'b1;
      EV_LINK: begin
        if ((mode_r == MODE_OPEN && ev.hit_closed)
            || (mode_r >= MODE_BANNED && ev.hit_stop)) begin
          mode_nxt  = MODE_ENTER;
          miss_nxt  = '0;
          typed_nxt = '0;
        end
      end
      default: ;
    endcase
    // An open lock with a change request waiting goes straight to change mode.
    if (mode_nxt == MODE_OPEN && pend_nxt) begin
      mode_nxt  = MODE_CHANGE;
      typed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_CREATE;
      stored_r <= '0;
      typed_r  <= '0;
      miss_r   <= '0;
      pend_r   <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      stored_r <= stored_nxt;
      typed_r  <= typed_nxt;
      miss_r   <= miss_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_comb begin
    res            = '0;
    res.send_valid = send;
    res.verdict    = verdict;
    res.lock_mode  = mode_nxt;
    res.misses     = miss_nxt;
  end

  a_verdict_sent: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.verdict |-> res.send_valid)
    else $error("verdict without a sent message");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= MODE_BANNED)
    else $error("lock mode out of range");

  a_open_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_OPEN |-> !pend_r)
    else $error("open lock kept a pending change request");

  a_correct_opens: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.verdict |-> res.lock_mode == MODE_OPEN
                                 || res.lock_mode == MODE_CHANGE)
    else $error("correct code did not open the lock");

endmodule

// ----- rtl/core/keypad_passcode_lock.sv -----
// ----------------------------------------------------------------------------
// Keypad passcode lock
// Door lock controller driven by keypad keys, change-passcode requests and
// control-link bytes, with a queue-style input and result interface.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// in_*      input      in_push / in_full       opcode, key_code, link_byte
// out_*     output     out_empty / out_pop     send_valid, verdict, lock_mode,
//                                              misses
// cfg_*     input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Every item yields exactly one result item. An item is classified in the
// cycle it is pushed and lands in a two-entry event queue; the back end
// executes one event per cycle while the result queue has room, so the
// sustained rate is one item per clock when the result side keeps popping.
// A result passes the event queue register and then the result queue
// register before it shows on the out ports and can be popped.
// Reset (rst_n low, synchronous) empties both queues, returns the lock to
// create mode with zero codes and counts, and loads the register defaults.
// A stalled result side fills the result queue, then the event queue, and
// then raises in_full; nothing is dropped. cfg_ready is always high.
//
module keypad_passcode_lock #(
  parameter int CODE_WIDTH = kpl_pkg::KPL_CODE_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input items.
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_key_code,
  input  logic [7:0] in_link_byte,
  // Result items.
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_send_valid,
  output logic       out_verdict,
  output logic [2:0] out_lock_mode,
  output logic [2:0] out_misses,
  // Configuration writes.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  import kpl_pkg::*;

  // Configuration registers. The user must change them only while the block
  // is idle (unenforced), so front end and back end may read them directly.
  logic [2:0] trial_limit_r;
  logic [7:0] closed_byte_r;
  logic [7:0] stop_alarm_byte_r;

  logic cfg_we;
  logic ev_valid;
  logic ev_pop;
  ev_t  ev;
  logic res_valid;
  logic res_full;
  res_t res;
  res_t out_res;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trial_limit_r     <= RST_TRIAL_LIMIT;
      closed_byte_r     <= RST_CLOSED;
      stop_alarm_byte_r <= RST_STOP_ALARM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIAL_LIMIT: trial_limit_r     <= cfg_data[2:0];
        CFG_CLOSED:      closed_byte_r     <= cfg_data;
        CFG_STOP_ALARM:  stop_alarm_byte_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: classify each item and queue it as an event.
  kpl_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_key_code     (in_key_code),
    .in_link_byte    (in_link_byte),
    .closed_byte     (closed_byte_r),
    .stop_alarm_byte (stop_alarm_byte_r),
    .ev_valid        (ev_valid),
    .ev              (ev),
    .ev_pop          (ev_pop)
  );

  // Back end: one event per cycle whenever the result queue has room.
  kpl_back #(
    .CODE_WIDTH (CODE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev_valid    (ev_valid),
    .ev          (ev),
    .ev_pop      (ev_pop),
    .trial_limit (trial_limit_r),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (!res_full)
  );

  // Result queue: holds finished results while the consumer stalls.
  kpl_fifo #(
    .WIDTH ($bits(res_t))
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_send_valid = out_res.send_valid;
  assign out_verdict    = out_res.verdict;
  assign out_lock_mode  = out_res.lock_mode;
  assign out_misses     = out_res.misses;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Keypad passcode lock testbench
// Drives keypad keys, change requests and link bytes into the lock through its
// queue-style ports and checks every result item against a cycle-free
// predictor of the lock, or a directed row's known result. A directed table
// covers the corner cases at the register defaults. Randomized phases follow,
// each with its own registers, and random gaps and stalls fall on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import kpl_pkg::*;

  // Opcode that the lock ignores, and the register index that maps to nothing.
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  // The longest quiet stretch of a correct run is the forced result stall,
  // so this idle limit is generous.
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_CYCLES     = 60;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RESET_CYCLES    = 7;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int NUM_PHASES      = 5;

  // One input item as the lock sees it.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] key;
    logic [7:0] link;
  } lock_event_t;

  // One row of the directed table. Where known is set, want is the result
  // that the row must produce; otherwise the predictor supplies it.
  typedef struct packed {
    lock_event_t ev;
    logic        known;
    res_t        want;
  } dir_row_t;

  // Architectural state of the lock, as the predictor tracks it.
  typedef struct packed {
    logic [2:0]                mode;
    logic [KPL_CODE_WIDTH-1:0] stored;
    logic [KPL_CODE_WIDTH-1:0] typed;
    logic [2:0]                misses;
    logic                      pending;
  } lock_state_t;

  localparam res_t NO_RES = '0;
  localparam int   NUM_DIR = 26;

  // The directed part starts right after reset, so the registers hold their
  // defaults: three trials, close byte 3 and stop-alarm byte 4. Typing
  // 7,0,0,0,0 gives 70000, which wraps to 4464 in sixteen bits.
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{'{OP_KEY,     "9",       8'h00}, 1'b1, '{1'b0, 1'b0, MODE_CREATE, 3'd0}},
    '{'{OP_KEY,     KEY_CLEAR, 8'hFF}, 1'b1, '{1'b0, 1'b0, MODE_CREATE, 3'd0}},
    '{'{OP_KEY,     "7",       8'h00}, 1'b0, NO_RES},
    '{'{OP_KEY,     "0",       8'h5A}, 1'b0, NO_RES},
    '{'{OP_KEY,     "0",       8'h00}, 1'b0, NO_RES},
    '{'{OP_KEY,     "0",       8'hA5}, 1'b0, NO_RES},
    '{'{OP_KEY,     "0",       8'h00}, 1'b0, NO_RES},
    '{'{OP_KEY,     KEY_ENTER, 8'h00}, 1'b1, '{1'b0, 1'b0, MODE_ENTER,  3'd0}},
    '{'{OP_KEY,     8'hFF,     8'hFF}, 1'b1, '{1'b0, 1'b0, MODE_ENTER,  3'd0}},
    '{'{OP_KEY,     KEY_ENTER, 8'h00}, 1'b1, '{1'b1, 1'b0, MODE_ENTER,  3'd1}},
    '{'{OP_LINK,    8'h00,     8'h04}, 1'b1, '{1'b0, 1'b0, MODE_ENTER,  3'd1}},
    '{'{OP_KEY,     KEY_ENTER, 8'h00}, 1'b1, '{1'b1, 1'b0, MODE_ENTER,  3'd2}},
    '{'{OP_IGNORED, KEY_ENTER, 8'h04}, 1'b1, '{1'b0, 1'b0, MODE_ENTER,  3'd2}},
    '{'{OP_KEY,     KEY_ENTER, 8'h00}, 1'b1, '{1'b1, 1'b0, MODE_BANNED, 3'd3}},
    '{'{OP_KEY,     "5",       8'h00}, 1'b1, '{1'b0, 1'b0, MODE_BANNED, 3'd3}},
    '{'{OP_LINK,    8'h00,     8'h03}, 1'b1, '{1'b0, 1'b0, MODE_BANNED, 3'd3}},
    '{'{OP_LINK,    8'h00,     8'h04}, 1'b1, '{1'b0, 1'b0, MODE_ENTER,  3'd0}},
    '{'{OP_CHANGE,  8'h00,     8'h00}, 1'b1, '{1'b0, 1'b0, MODE_ENTER,  3'd0}},
    '{'{OP_KEY,     "4",       8'h00}, 1'b0, NO_RES},
    '{'{OP_KEY,     "4",       8'h00}, 1'b0, NO_RES},
    '{'{OP_KEY,     "6",       8'h00}, 1'b0, NO_RES},
    '{'{OP_KEY,     "4",       8'h00}, 1'b0, NO_RES},
    // Correct code with a change request waiting: opens and moves on at once.
    '{'{OP_KEY,     KEY_ENTER, 8'h00}, 1'b1, '{1'b1, 1'b1, MODE_CHANGE, 3'd0}},
    '{'{OP_KEY,     KEY_ENTER, 8'h00}, 1'b1, '{1'b0, 1'b0, MODE_ENTER,  3'd0}},
    '{'{OP_KEY,     KEY_ENTER, 8'h00}, 1'b1, '{1'b1, 1'b1, MODE_OPEN,   3'd0}},
    '{'{OP_LINK,    8'hFF,     8'h03}, 1'b1, '{1'b0, 1'b0, MODE_ENTER,  3'd0}}
  };

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_push      = 1'b0;
  logic       in_full;
  logic [1:0] in_opcode    = '0;
  logic [7:0] in_key_code  = '0;
  logic [7:0] in_link_byte = '0;
  logic       out_empty;
  logic       out_pop      = 1'b0;
  logic       out_send_valid;
  logic       out_verdict;
  logic [2:0] out_lock_mode;
  logic [2:0] out_misses;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index    = '0;
  logic [7:0] cfg_data     = '0;

  // Predictor state and its copy of the registers.
  lock_state_t lock_st;
  logic [2:0]  trials_limit;
  logic [7:0]  close_code;
  logic [7:0]  unban_code;

  // Results the lock still owes, oldest first.
  res_t        awaited_results[$];
  lock_event_t key_batch[$];

  int mismatches   = 0;
  int progress     = 0;
  int quiet_cycles = 0;
  bit calm         = 1'b0;
  bit pressure_req = 1'b0;

  always #1 clk = ~clk;

  keypad_passcode_lock dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_key_code   (in_key_code),
    .in_link_byte  (in_link_byte),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_send_valid(out_send_valid),
    .out_verdict   (out_verdict),
    .out_lock_mode (out_lock_mode),
    .out_misses    (out_misses),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Digits shift into the typed code in decimal and wrap at the code width;
  // the clear key empties it. Returns 1 when the key was one of these.
  function automatic logic edit_typed(logic [7:0] key);
    logic [31:0] wide;
    if (key >= KEY_0 && key <= KEY_9) begin
      wide = 32'(lock_st.typed) * 32'd10 + 32'(key - KEY_0);
      lock_st.typed = wide[KPL_CODE_WIDTH-1:0];
      return 1'b1;
    end
    if (key == KEY_CLEAR) begin
      lock_st.typed = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one accepted item to the predicted lock and returns its result.
  function automatic res_t advance_lock(lock_event_t ev);
    res_t r;
    r = '0;
    case (ev.op)
      OP_KEY: begin
        if (lock_st.mode == MODE_CREATE || lock_st.mode == MODE_CHANGE) begin
          // Enter in a setup mode stores the passcode and arms the lock.
          if (!edit_typed(ev.key) && ev.key == KEY_ENTER) begin
            lock_st.stored  = lock_st.typed;
            lock_st.typed   = '0;
            lock_st.misses  = '0;
            lock_st.pending = 1'b0;
            lock_st.mode    = MODE_ENTER;
          end
        end else if (lock_st.mode == MODE_ENTER) begin
          if (!edit_typed(ev.key) && ev.key == KEY_ENTER) begin
            // The miss count goes up first and drops back on a match, so a
            // wrong code is judged against the limit with itself included.
            if (lock_st.misses < MISS_MAX) lock_st.misses = lock_st.misses + 3'd1;
            r.send_valid = 1'b1;
            if (lock_st.typed == lock_st.stored) begin
              r.verdict      = 1'b1;
              lock_st.misses = '0;
              lock_st.mode   = MODE_OPEN;
            end else if (lock_st.misses >= trials_limit) begin
              lock_st.mode = MODE_BANNED;
            end
            lock_st.typed = '0;
          end
        end
      end
      OP_CHANGE: lock_st.pending = 1'b1;
      OP_LINK: begin
        if ((lock_st.mode == MODE_OPEN && ev.link == close_code) ||
            (lock_st.mode >= MODE_BANNED && ev.link == unban_code)) begin
          lock_st.mode   = MODE_ENTER;
          lock_st.misses = '0;
          lock_st.typed  = '0;
        end
      end
      default: ;
    endcase
    // An open lock picks up a waiting change request after every item.
    if (lock_st.mode == MODE_OPEN && lock_st.pending) begin
      lock_st.mode  = MODE_CHANGE;
      lock_st.typed = '0;
    end
    r.lock_mode = lock_st.mode;
    r.misses    = lock_st.misses;
    return r;
  endfunction

  function automatic lock_event_t key_event(logic [7:0] key);
    return lock_event_t'{OP_KEY, key, 8'($urandom)};
  endfunction

  function automatic lock_event_t link_event(logic [7:0] link);
    return lock_event_t'{OP_LINK, 8'($urandom), link};
  endfunction

  function automatic logic [7:0] any_digit();
    return KEY_0 + 8'($urandom_range(0, 9));
  endfunction

  // Queues the decimal keys of a code, most significant digit first.
  task automatic append_code(logic [KPL_CODE_WIDTH-1:0] code);
    int digits[$];
    int v;
    v = int'(code);
    do begin
      digits.push_front(v % 10);
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) key_batch.push_back(key_event(KEY_0 + 8'(digits[i])));
  endtask

  // Picks the next short sequence from the predicted mode. Most of it is a
  // well-formed use of the lock; a share is plain noise on every field.
  task automatic plan_batch();
    int r;
    int n;
    int hit_pct;
    if ($urandom_range(0, 99) < 12) begin
      key_batch.push_back(lock_event_t'{2'($urandom_range(0, 3)), 8'($urandom),
                                        8'($urandom)});
      return;
    end
    r = $urandom_range(0, 99);
    case (lock_st.mode)
      MODE_CREATE, MODE_CHANGE: begin
        if (r < 25) key_batch.push_back(key_event(KEY_CLEAR));
        n = $urandom_range(0, 6);
        repeat (n) key_batch.push_back(key_event(any_digit()));
        key_batch.push_back(key_event(KEY_ENTER));
      end
      MODE_ENTER: begin
        // With a high trial limit, mostly miss so the count climbs to the top.
        hit_pct = (trials_limit >= 3'd5) ? 15 : 40;
        if (r < hit_pct) begin
          if ($urandom_range(0, 3) == 0) begin
            key_batch.push_back(key_event(any_digit()));
            key_batch.push_back(key_event(KEY_CLEAR));
          end
          append_code(lock_st.stored);
          key_batch.push_back(key_event(KEY_ENTER));
        end else if (r < 88) begin
          n = $urandom_range(0, 5);
          repeat (n) key_batch.push_back(key_event(any_digit()));
          key_batch.push_back(key_event(KEY_ENTER));
        end else if (r < 95) begin
          key_batch.push_back(lock_event_t'{OP_CHANGE, 8'($urandom), 8'($urandom)});
        end else begin
          key_batch.push_back(link_event($urandom_range(0, 1) ? unban_code : close_code));
        end
      end
      MODE_OPEN: begin
        if (r < 45) key_batch.push_back(link_event(close_code));
        else if (r < 70) key_batch.push_back(lock_event_t'{OP_CHANGE, 8'($urandom),
                                                           8'($urandom)});
        else if (r < 85) key_batch.push_back(key_event($urandom_range(0, 1) ? KEY_ENTER
                                                                            : any_digit()));
        else key_batch.push_back(link_event(8'($urandom)));
      end
      default: begin
        if (r < 50) key_batch.push_back(link_event(unban_code));
        else if (r < 70) key_batch.push_back(key_event(KEY_ENTER));
        else if (r < 85) key_batch.push_back(link_event($urandom_range(0, 1) ? close_code
                                                                             : 8'($urandom)));
        else key_batch.push_back(key_event(any_digit()));
      end
    endcase
  endtask

  // Offers one item and waits for the lock to take it. The push line stays
  // high into the next item unless a gap is drawn. Only items that change the
  // lock or send a verdict count toward a phase.
  task automatic offer_item(lock_event_t ev, logic known, res_t want);
    lock_state_t snapshot;
    res_t        r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_opcode    <= ev.op;
    in_key_code  <= ev.key;
    in_link_byte <= ev.link;
    @(posedge clk);
    while (in_full) @(posedge clk);
    snapshot = lock_st;
    r = advance_lock(ev);
    if (r.send_valid || lock_st != snapshot) progress++;
    awaited_results.push_back(known ? want : r);
  endtask

  // Lets every owed result come back, then waits out the drain, so the lock is
  // idle before the registers change or the run ends.
  task automatic settle_block();
    in_push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers, and the unmapped index when asked. The trial
  // limit lives in the low three bits, so the upper data bits are random.
  task automatic load_registers(logic [2:0] trials, logic [7:0] closed, logic [7:0] unban,
                                bit spare);
    logic [1:0] idx[$];
    logic [7:0] dat[$];
    idx = '{CFG_TRIAL_LIMIT, CFG_CLOSED, CFG_STOP_ALARM};
    dat = '{{5'($urandom), trials}, closed, unban};
    if (spare) begin
      idx.push_back(CFG_SPARE);
      dat.push_back(8'($urandom));
    end
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= dat[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        CFG_TRIAL_LIMIT: trials_limit = dat[i][2:0];
        CFG_CLOSED:      close_code   = dat[i];
        CFG_STOP_ALARM:  unban_code   = dat[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: compare each popped result with the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_results.size() == 0) begin
        $error("result item with nothing expected: mode %0d misses %0d",
               out_lock_mode, out_misses);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("send_valid", 3'(want.send_valid), 3'(out_send_valid));
        check_field("verdict",    3'(want.verdict),    3'(out_verdict));
        check_field("lock_mode",  want.lock_mode,      out_lock_mode);
        check_field("misses",     want.misses,         out_misses);
      end
    end
  end

  // Result consumer: mostly pops, with short random stalls. Once per run it
  // holds off for a long stretch so both internal queues fill and the input
  // side has to raise full. In the calm phase it never stalls.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (pressure_req) begin
        pressure_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: a lock that stops taking or giving items ends the run.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("keypad_passcode_lock verification failed");
      $finish;
    end
  end

  // Main sequence: reset, the directed table, then the random phases. The
  // first random phase bans on the first miss and gets the long result stall;
  // the second allows the most misses; the last runs at the register defaults
  // with no gaps on either side.
  initial begin
    int phase;
    lock_st      = '0;
    lock_st.mode = MODE_CREATE;
    trials_limit = RST_TRIAL_LIMIT;
    close_code   = RST_CLOSED;
    unban_code   = RST_STOP_ALARM;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) offer_item(DIR_ROWS[i].ev, DIR_ROWS[i].known, DIR_ROWS[i].want);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle_block();
      case (phase)
        0: load_registers(3'd0, 8'h00, 8'hFF, 1'b1);
        1: load_registers(3'd7, 8'hFF, 8'h00, 1'b0);
        2: load_registers(3'd1, 8'($urandom), 8'($urandom), 1'b0);
        // Close and stop-alarm bytes equal: one byte ends both states.
        3: load_registers(3'($urandom_range(0, 7)), 8'h5A, 8'h5A, 1'b0);
        default: begin
          load_registers(RST_TRIAL_LIMIT, RST_CLOSED, RST_STOP_ALARM, 1'b0);
          calm = 1'b1;
        end
      endcase
      if (phase == 0) pressure_req = 1'b1;
      progress = 0;
      while (progress < ITEMS_PER_PHASE) begin
        plan_batch();
        while (key_batch.size() != 0) offer_item(key_batch.pop_front(), 1'b0, NO_RES);
      end
    end

    settle_block();
    if (mismatches == 0)
      $display("keypad_passcode_lock verification clean");
    else
      $display("keypad_passcode_lock verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/kpl_pkg.sv
rtl/core/kpl_fifo.sv
rtl/core/kpl_front.sv
rtl/core/kpl_back.sv
rtl/core/keypad_passcode_lock.sv
dv/tb_top.sv
